@@ hw/rtl/hsv2rgb_pkg.sv @@
// Shared constants, codes and stage bundles of the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  // Field widths
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CHAN_W = 8;

  // Input ranges and fixed-point scale (common denominator 10000 * 3840)
  localparam int unsigned HUE_MAX      = 23040;
  localparam int unsigned PCT_MAX      = 100;
  localparam int unsigned SECTOR_UNITS = 3840;
  localparam int unsigned PAIR_UNITS   = 2 * SECTOR_UNITS;
  localparam int unsigned V_SCALE      = PCT_MAX * SECTOR_UNITS;
  localparam int unsigned FULL_SCALE   = PCT_MAX * V_SCALE;
  localparam int unsigned ROUND_HALF   = FULL_SCALE / 2;
  localparam int unsigned CHAN_MAX     = 255;

  // Internal widths
  localparam int unsigned SV_W   = 2 * PCT_W;
  localparam int unsigned FRAC_W = 12;
  localparam int unsigned NUM_W  = 26;
  localparam int unsigned BIG_W  = 34;

  // Divide by FULL_SCALE = 2^12 * 9375: shift out 2^12, then multiply by
  // ceil(2^36 / 9375), which is exact for any 22-bit dividend
  localparam int unsigned DIV_SHIFT   = 12;
  localparam int unsigned QIN_W       = BIG_W - DIV_SHIFT;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_M     = 7330078;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned PROD_W      = QIN_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int unsigned LATENCY = 7;

  // 60-degree hue sectors; the wrap code is hue exactly 360 degrees
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5,
    SECT_WRAP    = 3'd6
  } sector_e;

  // Chroma terms handed from the front end to the mixer
  typedef struct packed {
    logic              valid;
    sector_e           sector;
    logic [NUM_W-1:0]  vfull;
    logic [NUM_W-1:0]  chroma;
    logic [NUM_W-1:0]  second;
  } chroma_t;

endpackage

`default_nettype wire

@@ hw/rtl/hsv2rgb_front.sv @@
// Front end: input clamp, sector decode, chroma and secondary products.
`default_nettype none

module hsv2rgb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue_i,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     sat_i,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     val_i,
  output hsv2rgb_pkg::chroma_t              chroma_o
);

  localparam int unsigned SU = hsv2rgb_pkg::SECTOR_UNITS;

  logic [hsv2rgb_pkg::HUE_W-1:0]   hue_c, base, offs_full;
  logic [hsv2rgb_pkg::PCT_W-1:0]   sat_c, val_c;
  logic                            odd;
  hsv2rgb_pkg::sector_e            sect_d;
  logic [hsv2rgb_pkg::FRAC_W-1:0]  offs, ramp_d;

  logic                            s1_valid_q;
  hsv2rgb_pkg::sector_e            s1_sect_q;
  logic [hsv2rgb_pkg::FRAC_W-1:0]  s1_ramp_q;
  logic [hsv2rgb_pkg::PCT_W-1:0]   s1_sat_q, s1_val_q;

  logic [hsv2rgb_pkg::SV_W-1:0]    sv_d, s2_sv_q;
  logic [hsv2rgb_pkg::NUM_W-1:0]   vfull_d, s2_vfull_q;
  logic                            s2_valid_q;
  hsv2rgb_pkg::sector_e            s2_sect_q;
  logic [hsv2rgb_pkg::FRAC_W-1:0]  s2_ramp_q;

  hsv2rgb_pkg::chroma_t            chroma_d, chroma_q;

  // Clamp the inputs to their ranges
  assign hue_c = (hue_i > hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_MAX))
               ? hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_MAX) : hue_i;
  assign sat_c = (sat_i > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX))
               ? hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX) : sat_i;
  assign val_c = (val_i > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX))
               ? hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX) : val_i;

  // Find the 60-degree sector and its start; odd sectors ramp down
  always_comb begin
    if (hue_c >= hsv2rgb_pkg::HUE_W'(6 * SU)) begin
      sect_d = hsv2rgb_pkg::SECT_WRAP;
      base   = hsv2rgb_pkg::HUE_W'(6 * SU);
      odd    = 1'b0;
    end else if (hue_c >= hsv2rgb_pkg::HUE_W'(5 * SU)) begin
      sect_d = hsv2rgb_pkg::SECT_MAG_RED;
      base   = hsv2rgb_pkg::HUE_W'(5 * SU);
      odd    = 1'b1;
    end else if (hue_c >= hsv2rgb_pkg::HUE_W'(4 * SU)) begin
      sect_d = hsv2rgb_pkg::SECT_BLU_MAG;
      base   = hsv2rgb_pkg::HUE_W'(4 * SU);
      odd    = 1'b0;
    end else if (hue_c >= hsv2rgb_pkg::HUE_W'(3 * SU)) begin
      sect_d = hsv2rgb_pkg::SECT_CYN_BLU;
      base   = hsv2rgb_pkg::HUE_W'(3 * SU);
      odd    = 1'b1;
    end else if (hue_c >= hsv2rgb_pkg::HUE_W'(2 * SU)) begin
      sect_d = hsv2rgb_pkg::SECT_GRN_CYN;
      base   = hsv2rgb_pkg::HUE_W'(2 * SU);
      odd    = 1'b0;
    end else if (hue_c >= hsv2rgb_pkg::HUE_W'(SU)) begin
      sect_d = hsv2rgb_pkg::SECT_YEL_GRN;
      base   = hsv2rgb_pkg::HUE_W'(SU);
      odd    = 1'b1;
    end else begin
      sect_d = hsv2rgb_pkg::SECT_RED_YEL;
      base   = '0;
      odd    = 1'b0;
    end
  end

  // Ramp of the secondary component within the sector
  assign offs_full = hue_c - base;
  assign offs      = offs_full[hsv2rgb_pkg::FRAC_W-1:0];
  assign ramp_d    = odd ? (hsv2rgb_pkg::FRAC_W'(SU) - offs) : offs;

  // Saturation times value, and value at full scale
  assign sv_d    = hsv2rgb_pkg::SV_W'(s1_sat_q) * hsv2rgb_pkg::SV_W'(s1_val_q);
  assign vfull_d = hsv2rgb_pkg::NUM_W'(s1_val_q) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::V_SCALE);

  // Chroma and secondary numerators
  always_comb begin
    chroma_d.valid  = s2_valid_q;
    chroma_d.sector = s2_sect_q;
    chroma_d.vfull  = s2_vfull_q;
    chroma_d.chroma = hsv2rgb_pkg::NUM_W'(s2_sv_q) * hsv2rgb_pkg::NUM_W'(SU);
    chroma_d.second = hsv2rgb_pkg::NUM_W'(s2_sv_q) * hsv2rgb_pkg::NUM_W'(s2_ramp_q);
  end

  // Advance the beat through the three front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_sect_q  <= hsv2rgb_pkg::SECT_RED_YEL;
      s1_ramp_q  <= '0;
      s1_sat_q   <= '0;
      s1_val_q   <= '0;
      s2_valid_q <= 1'b0;
      s2_sect_q  <= hsv2rgb_pkg::SECT_RED_YEL;
      s2_ramp_q  <= '0;
      s2_sv_q    <= '0;
      s2_vfull_q <= '0;
      chroma_q   <= '0;
    end else begin
      s1_valid_q <= valid_i;
      s1_sect_q  <= sect_d;
      s1_ramp_q  <= ramp_d;
      s1_sat_q   <= sat_c;
      s1_val_q   <= val_c;
      s2_valid_q <= s1_valid_q;
      s2_sect_q  <= s1_sect_q;
      s2_ramp_q  <= s1_ramp_q;
      s2_sv_q    <= sv_d;
      s2_vfull_q <= vfull_d;
      chroma_q   <= chroma_d;
    end
  end

  assign chroma_o = chroma_q;

endmodule

`default_nettype wire

@@ hw/rtl/hsv2rgb_mix.sv @@
// Mixer: offset term and sector permutation of the three channel numerators.
`default_nettype none

module hsv2rgb_mix (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  hsv2rgb_pkg::chroma_t                    chroma_i,
  output logic                                    valid_o,
  output logic [2:0][hsv2rgb_pkg::NUM_W-1:0]      num_o
);

  logic                                 valid_q;
  logic [2:0][hsv2rgb_pkg::NUM_W-1:0]   num_d, num_q;
  logic [hsv2rgb_pkg::NUM_W-1:0]        hi, mid, lo;

  // Form the bright, middle and dark levels, then place them by sector
  always_comb begin
    lo  = chroma_i.vfull - chroma_i.chroma;
    hi  = chroma_i.vfull;
    mid = chroma_i.second + lo;
    case (chroma_i.sector) inside
      hsv2rgb_pkg::SECT_RED_YEL: num_d = {lo, mid, hi};
      hsv2rgb_pkg::SECT_YEL_GRN: num_d = {lo, hi, mid};
      hsv2rgb_pkg::SECT_GRN_CYN: num_d = {mid, hi, lo};
      hsv2rgb_pkg::SECT_CYN_BLU: num_d = {hi, mid, lo};
      hsv2rgb_pkg::SECT_BLU_MAG: num_d = {hi, lo, mid};
      default:                   num_d = {mid, lo, hi};
    endcase
  end

  // Advance the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chroma_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;

endmodule

`default_nettype wire

@@ hw/rtl/hsv2rgb_scale.sv @@
// Scaler: map each channel numerator to an 8-bit level, rounded to nearest.
`default_nettype none

module hsv2rgb_scale (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic [2:0][hsv2rgb_pkg::NUM_W-1:0]      num_i,
  output logic                                    valid_o,
  output logic [2:0][hsv2rgb_pkg::CHAN_W-1:0]     chan_o
);

  logic [2:0]                           valid_q;
  logic [2:0][hsv2rgb_pkg::QIN_W-1:0]   qin_d, qin_q;
  logic [2:0][hsv2rgb_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic [2:0][hsv2rgb_pkg::CHAN_W-1:0]  chan_d, chan_q;

  for (genvar gi = 0; gi < 3; gi++) begin : g_lane
    logic [hsv2rgb_pkg::BIG_W-1:0]  big;
    logic [hsv2rgb_pkg::QUOT_W-1:0] quot;

    // Scale by 255, add half the denominator, drop the power-of-two factor
    assign big = hsv2rgb_pkg::BIG_W'(num_i[gi]) * hsv2rgb_pkg::BIG_W'(hsv2rgb_pkg::CHAN_MAX)
               + hsv2rgb_pkg::BIG_W'(hsv2rgb_pkg::ROUND_HALF);
    assign qin_d[gi] = big[hsv2rgb_pkg::BIG_W-1:hsv2rgb_pkg::DIV_SHIFT];

    // Divide the rest by reciprocal multiplication
    assign prod_d[gi] = hsv2rgb_pkg::PROD_W'(qin_q[gi])
                      * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::RECIP_M);

    // Take the quotient and hold it at full scale
    assign quot = prod_q[gi][hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::RECIP_SHIFT];
    assign chan_d[gi] = (quot > hsv2rgb_pkg::QUOT_W'(hsv2rgb_pkg::CHAN_MAX))
                      ? hsv2rgb_pkg::CHAN_W'(hsv2rgb_pkg::CHAN_MAX)
                      : quot[hsv2rgb_pkg::CHAN_W-1:0];
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    qin_q  <= qin_d;
    prod_q <= prod_d;
    chan_q <= chan_d;
  end

  assign valid_o = valid_q[2];
  assign chan_o  = chan_q;

endmodule

`default_nettype wire

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter pipeline.
`default_nettype none

// Converts one HSV colour per clock into 8-bit RGB. Raise start_i with hue_i
// (1/64 degree, 0..23040), saturation_i and brightness_i (percent, 0..100);
// inputs above range are clamped. busy_o is always low, so a colour is taken
// on every cycle that start_i is high. Each result appears for one cycle with
// done_o high, after it passes the seven-register pipeline (clamp and sector,
// chroma, products, sector mix, scale by 255, reciprocal multiply, quotient).
// The receiver cannot hold results off, so it must take every beat that
// done_o marks.
module hsv_to_rgb_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue_i,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     saturation_i,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     brightness_i,
  output logic                              done_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    red_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    green_o,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    blue_o
);

  hsv2rgb_pkg::chroma_t                  chroma;
  logic                                  mix_valid;
  logic [2:0][hsv2rgb_pkg::NUM_W-1:0]    mix_num;
  logic [2:0][hsv2rgb_pkg::CHAN_W-1:0]   chan;
  logic                                  accept;

  // Take a beat on every start
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  hsv2rgb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .hue_i    (hue_i),
    .sat_i    (saturation_i),
    .val_i    (brightness_i),
    .chroma_o (chroma)
  );

  hsv2rgb_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .chroma_i (chroma),
    .valid_o  (mix_valid),
    .num_o    (mix_num)
  );

  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .num_i   (mix_num),
    .valid_o (done_o),
    .chan_o  (chan)
  );

  assign red_o   = chan[0];
  assign green_o = chan[1];
  assign blue_o  = chan[2];

endmodule

`default_nettype wire

@@ dv/hsv_to_rgb_checker.sv @@
// Checker for the HSV to RGB converter: predicts each colour and compares the result beats.
`timescale 1ns / 1ps

module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [HUE_W-1:0]  hue_i,
  input  logic [PCT_W-1:0]  saturation_i,
  input  logic [PCT_W-1:0]  brightness_i,
  input  logic              done_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  // Exact rational arithmetic over 10000 * 3840
  localparam longint unsigned HUE_TOP   = 23040;
  localparam longint unsigned PCT_TOP   = 100;
  localparam longint unsigned SIXTH     = 3840;
  localparam longint unsigned DENOM     = 38400000;
  localparam longint unsigned BYTE_TOP  = 255;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  rgb_t        expected_rgb[$];
  int unsigned mismatches = 0;

  // Scale a numerator by 255, round half up and clamp to one byte
  function automatic logic [CHAN_W-1:0] to_channel(input longint unsigned num);
    longint unsigned scaled;
    scaled = (num * BYTE_TOP + DENOM / 2) / DENOM;
    if (scaled > BYTE_TOP) scaled = BYTE_TOP;
    return scaled[CHAN_W-1:0];
  endfunction

  function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue,
                                       input logic [PCT_W-1:0] sat,
                                       input logic [PCT_W-1:0] val);
    longint unsigned h, s, v, pos, gap, ramp, chroma, second, offset;
    longint unsigned hi, mid, lo;
    sector_e         sect;
    rgb_t            rgb;
    // Clamp to range
    h = (hue > HUE_TOP) ? HUE_TOP : longint'(hue);
    s = (sat > PCT_TOP) ? PCT_TOP : longint'(sat);
    v = (val > PCT_TOP) ? PCT_TOP : longint'(val);
    // Sector and ramp within the pair of sectors
    sect = sector_e'(3'(h / SIXTH));
    pos  = h % (2 * SIXTH);
    gap  = (pos > SIXTH) ? pos - SIXTH : SIXTH - pos;
    ramp = SIXTH - gap;
    chroma = s * v * SIXTH;
    second = s * v * ramp;
    offset = v * PCT_TOP * SIXTH - chroma;
    hi  = chroma + offset;
    mid = second + offset;
    lo  = offset;
    // Place (c, x, 0) by sector; the wrap at 360 degrees shares the last one
    case (sect)
      SECT_RED_YEL: begin
        rgb.red = to_channel(hi);  rgb.green = to_channel(mid); rgb.blue = to_channel(lo);
      end
      SECT_YEL_GRN: begin
        rgb.red = to_channel(mid); rgb.green = to_channel(hi);  rgb.blue = to_channel(lo);
      end
      SECT_GRN_CYN: begin
        rgb.red = to_channel(lo);  rgb.green = to_channel(hi);  rgb.blue = to_channel(mid);
      end
      SECT_CYN_BLU: begin
        rgb.red = to_channel(lo);  rgb.green = to_channel(mid); rgb.blue = to_channel(hi);
      end
      SECT_BLU_MAG: begin
        rgb.red = to_channel(mid); rgb.green = to_channel(lo);  rgb.blue = to_channel(hi);
      end
      default: begin
        rgb.red = to_channel(hi);  rgb.green = to_channel(lo);  rgb.blue = to_channel(mid);
      end
    endcase
    return rgb;
  endfunction

  // Check result beats against the oldest prediction, then queue new colours
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_rgb.size() == 0) begin
          $error("result beat with no colour pending: r=%0d g=%0d b=%0d",
                 red_i, green_i, blue_i);
          mismatches++;
        end else begin
          want = expected_rgb.pop_front();
          if (red_i !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, red_i);
            mismatches++;
          end
          if (green_i !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, green_i);
            mismatches++;
          end
          if (blue_i !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, blue_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i)
        expected_rgb.push_back(predict_rgb(hue_i, saturation_i, brightness_i));
    end
    pending_o    <= expected_rgb.size();
    fail_count_o <= mismatches;
  end

endmodule

@@ dv/tb_hsv_to_rgb_converter.sv @@
// Testbench top for the HSV to RGB converter: drives colours and reports the verdict.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BEATS = 1400;
  localparam int unsigned PHASE_COUNT  = 4;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [HUE_W-1:0]  hue = '0;
  logic [PCT_W-1:0]  saturation = '0;
  logic [PCT_W-1:0]  brightness = '0;
  logic              done;
  logic [CHAN_W-1:0] red, green, blue;

  int unsigned pending_colours;
  int unsigned fail_count;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  hsv_to_rgb_converter dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .hue_i        (hue),
    .saturation_i (saturation),
    .brightness_i (brightness),
    .done_o       (done),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  hsv_to_rgb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .hue_i        (hue),
    .saturation_i (saturation),
    .brightness_i (brightness),
    .done_i       (done),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .pending_o    (pending_colours),
    .fail_count_o (fail_count)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
    end
  end

  // Drive one colour beat; entered and left at a falling edge
  task automatic send_colour(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
                             input logic [PCT_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every predicted colour has come back
  task automatic drain_colours();
    start <= 1'b0;
    @(negedge clk);
    while (pending_colours != 0) @(negedge clk);
  endtask

  // Mostly in range, with the extremes and some over-range values
  function automatic logic [PCT_W-1:0] rand_pct();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return PCT_W'($urandom_range(100));
    if (pick < 90) return ($urandom_range(1)) ? PCT_W'(100) : PCT_W'(0);
    return PCT_W'($urandom_range(127));
  endfunction

  initial begin
    logic [HUE_W-1:0] h;
    int unsigned      pick;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, sector boundaries, grey, hue wrap and clamping
    send_colour(0, 0, 0);
    send_colour(0, 0, 100);
    send_colour(0, 0, 57);
    send_colour(0, 100, 100);
    for (int k = 1; k <= 6; k++) send_colour(HUE_W'(k * 3840), 100, 100);
    send_colour(1920, 100, 100);
    send_colour(3839, 100, 100);
    send_colour(3841, 100, 100);
    send_colour(9600, 63, 77);
    send_colour(23039, 100, 100);
    send_colour(23041, 100, 100);
    send_colour(32767, 127, 127);
    send_colour(5000, 127, 50);
    send_colour(12345, 50, 127);
    send_colour(16384, 101, 1);
    send_colour(21000, 1, 99);
    drain_colours();

    // Random phases: no idling, sender idle mostly, none again, light idling
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        1:       idle_pct = 88;
        3:       idle_pct = 12;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_BEATS / PHASE_COUNT; n++) begin
        pick = $urandom_range(99);
        if (pick < 70)      h = HUE_W'($urandom_range(23040));
        else if (pick < 85) h = HUE_W'($urandom_range(6) * 3840 + $urandom_range(2)) - 1'b1;
        else                h = HUE_W'($urandom_range(32767));
        send_colour(h, rand_pct(), rand_pct());
      end
      drain_colours();
    end

    // Let the pipeline settle before the verdict
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0 && pending_colours == 0) begin
      $display("** hsv_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule
